// ===== design/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pattern controller package
// Shared types, register indexes, pattern tables and arithmetic constants.
// ----------------------------------------------------------------------------
package lpc_pkg;

   // Field and register widths.
   localparam int DUTY_W     = 13;
   localparam int PERIOD_W   = 16;
   localparam int SEQ_W      = 8;
   localparam int PCT_W      = 7;
   localparam int POS_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Default width of the tick counter.
   localparam int TICK_BITS_DEF = 16;

   // Pattern geometry.
   localparam int SYNC_LEN    = 4;
   localparam int CODE_LEN    = 24;
   localparam int PATTERN_LEN = 16;
   localparam int SEQ_TOTAL   = SYNC_LEN + CODE_LEN;
   localparam int CODE_BYTES  = 2 * (CODE_LEN / 2);

   // Percent scaling: floor(m * p / 100) == (m * ceil(2^26 / 100) * p) >> 26
   // for every m below 8192 and p up to 100.
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);
   localparam int SCALED_W    = DUTY_W + RECIP_W;
   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_DUTY     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAST_PERIOD  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_PERIOD  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CODE_PERIOD  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEQ_ID       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_LEVEL = 3'd5;

   // Commands carried by an input item.
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_OFF     = 3'd1,
      CMD_ON      = 3'd2,
      CMD_DUTY    = 3'd3,
      CMD_FLASH   = 3'd4,
      CMD_FBREATH = 3'd5,
      CMD_SBREATH = 3'd6,
      CMD_CODE    = 3'd7
   } cmd_type;

   // Operating modes.
   typedef enum logic [2:0] {
      MODE_OFF     = 3'd0,
      MODE_ON      = 3'd1,
      MODE_DUTY    = 3'd2,
      MODE_FLASH   = 3'd3,
      MODE_FBREATH = 3'd4,
      MODE_SBREATH = 3'd5,
      MODE_CODE    = 3'd6
   } mode_type;

   // Input item.
   typedef struct packed {
      logic [2:0]       command;
      logic [PCT_W-1:0] duty_percent;
   } req_type;

   // Result item.
   typedef struct packed {
      logic              pwm_running;
      logic              pin_level;
      logic [DUTY_W-1:0] duty_value;
      logic [2:0]        mode;
   } rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic [DUTY_W-1:0]   max_duty;
      logic [PERIOD_W-1:0] fast_period;
      logic [PERIOD_W-1:0] slow_period;
      logic [PERIOD_W-1:0] code_period;
      logic [SEQ_W-1:0]    seq_id;
      logic                active_level;
   } cfg_type;

   // Stored controller state (the tick counter is kept beside it).
   typedef struct packed {
      mode_type          mode;
      logic [POS_W-1:0]  position;
      logic [DUTY_W-1:0] duty_level;
   } state_rec_type;

   localparam state_rec_type STATE_RESET = '{mode: MODE_FLASH, position: '0, duty_level: '0};

   // Pattern tables.
   localparam logic [7:0] SYNC_BYTES [4] = '{8'd255, 8'd255, 8'd255, 8'd64};
   localparam logic [3:0] DATA_CELLS [8] = '{4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11};
   localparam logic [7:0] FAST_BREATH_TAB [16] = '{
      8'd0, 8'd32, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224,
      8'd255, 8'd224, 8'd192, 8'd160, 8'd128, 8'd96, 8'd64, 8'd32};
   localparam logic [7:0] SLOW_BREATH_TAB [16] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255};
   localparam logic [7:0] FLASH_TAB [16] = '{
      8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
      8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};

endpackage

// ===== design/led_pattern_controller.sv =====
// ----------------------------------------------------------------------------
// LED pattern controller
// Drives one LED as a static pin or by PWM duty from commands and 1 ms ticks:
// off, on, fixed duty, fast flash, fast and slow breath and a sequence code.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer when           Payload
//   req_      in         req_valid & req_ready   req_data  (command, duty percent)
//   rsp_      out        rsp_valid & rsp_ready   rsp_data  (pwm, pin, duty, mode)
//   csr_      in         csr_valid & csr_ready   csr_index, csr_wdata
//
// One item per cycle while results are taken; a result is valid once its
// transfer has passed the state memory read register (loaded as the transfer
// is taken) and then the update stage into the output register. The state
// memory is written when the update stage hands on its result; a read that
// meets that write takes the new word. A stalled result holds the update
// stage, and a new transfer is taken only while that stage can move.
// Reset is synchronous; no transfer is taken during it.
//
module led_pattern_controller
   import lpc_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type               cfg_ff;
   logic [SCALED_W-1:0]   max_scaled_ff;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_type               s1_req_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   logic                  req_xfer;
   logic                  s1_advance;
   state_rec_type         rd_rec;
   logic [TICK_BITS-1:0]  rd_tick;
   state_rec_type         nxt_rec;
   logic [TICK_BITS-1:0]  nxt_tick;
   rsp_type               nxt_rsp;

   // Configuration registers.
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_duty     <= DUTY_W'(8191);
         cfg_ff.fast_period  <= PERIOD_W'(50);
         cfg_ff.slow_period  <= PERIOD_W'(200);
         cfg_ff.code_period  <= PERIOD_W'(100);
         cfg_ff.seq_id       <= '0;
         cfg_ff.active_level <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_DUTY:     cfg_ff.max_duty     <= csr_wdata[DUTY_W-1:0];
            CSR_FAST_PERIOD:  cfg_ff.fast_period  <= csr_wdata[PERIOD_W-1:0];
            CSR_SLOW_PERIOD:  cfg_ff.slow_period  <= csr_wdata[PERIOD_W-1:0];
            CSR_CODE_PERIOD:  cfg_ff.code_period  <= csr_wdata[PERIOD_W-1:0];
            CSR_SEQ_ID:       cfg_ff.seq_id       <= csr_wdata[SEQ_W-1:0];
            CSR_ACTIVE_LEVEL: cfg_ff.active_level <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Full scale premultiplied by the reciprocal of 100 for set-duty scaling.
   always_ff @(posedge clock) begin
      max_scaled_ff <= SCALED_W'(cfg_ff.max_duty) * SCALED_W'(RECIP_100);
   end

   // Handshake and stage control.
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~reset & (~s1_valid_ff | s1_advance);
   assign req_xfer   = req_valid & req_ready;

   assign s1_valid_in  = req_xfer | (s1_valid_ff & ~s1_advance);
   assign rsp_valid_in = s1_advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= nxt_rsp;
      end
   end

   // State memory: read on transfer, write back as the update stage moves on.
   lpc_state_ram #(
      .TICK_BITS (TICK_BITS)
   ) u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_rec  (rd_rec),
      .rd_tick (rd_tick),
      .wr_en   (s1_advance),
      .wr_rec  (nxt_rec),
      .wr_tick (nxt_tick)
   );

   // Update stage.
   lpc_step #(
      .TICK_BITS (TICK_BITS)
   ) u_step (
      .req        (s1_req_ff),
      .cur_rec    (rd_rec),
      .cur_tick   (rd_tick),
      .cfg        (cfg_ff),
      .max_scaled (max_scaled_ff),
      .nxt_rec    (nxt_rec),
      .nxt_tick   (nxt_tick),
      .rsp        (nxt_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/lpc_state_ram.sv =====
// ----------------------------------------------------------------------------
// LED pattern controller state memory
// Single-entry synchronous memory holding the controller state and the tick
// counter, with a registered read and write-first forwarding.
// ----------------------------------------------------------------------------
module lpc_state_ram
   import lpc_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   output state_rec_type        rd_rec,
   output logic [TICK_BITS-1:0] rd_tick,
   input  logic                 wr_en,
   input  state_rec_type        wr_rec,
   input  logic [TICK_BITS-1:0] wr_tick
);

   localparam int WORD_W = $bits(state_rec_type) + TICK_BITS;

   logic [WORD_W-1:0] mem_ff [1];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] wr_word;

   assign wr_word = {wr_rec, wr_tick};

   // Write port; reset loads the power-up state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff[0] <= {STATE_RESET, {TICK_BITS{1'b0}}};
      end else if (wr_en) begin
         mem_ff[0] <= wr_word;
      end
   end

   // Read port; a write in the same cycle is passed straight through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= wr_en ? wr_word : mem_ff[0];
      end
   end

   assign rd_rec  = state_rec_type'(rd_word_ff[WORD_W-1:TICK_BITS]);
   assign rd_tick = rd_word_ff[TICK_BITS-1:0];

endmodule

// ===== design/lpc_step.sv =====
// ----------------------------------------------------------------------------
// LED pattern controller update logic
// Applies one command or tick to the state read from memory and forms the
// result item from the updated state.
// ----------------------------------------------------------------------------
module lpc_step
   import lpc_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  req_type              req,
   input  state_rec_type        cur_rec,
   input  logic [TICK_BITS-1:0] cur_tick,
   input  cfg_type              cfg,
   input  logic [SCALED_W-1:0]  max_scaled,
   output state_rec_type        nxt_rec,
   output logic [TICK_BITS-1:0] nxt_tick,
   output rsp_type              rsp
);

   localparam int CMP_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
   localparam logic [7:0] CODE_X = SYNC_BYTES[SYNC_LEN-2];
   localparam logic [7:0] CODE_Y = SYNC_BYTES[SYNC_LEN-1];

   cmd_type                cmd;
   mode_type               cmd_mode;
   logic                   is_pattern;
   logic [PERIOD_W-1:0]    period;
   logic [TICK_BITS-1:0]   tick_inc;
   logic                   do_step;
   logic [POS_W-1:0]       pos_len;
   logic [POS_W-1:0]       pos_eff;
   logic [POS_W-1:0]       pos_next;
   logic [POS_W-1:0]       code_off;
   logic [11:0]            code_bit;
   logic [15:0]            flip;
   logic [7:0]             code_byte;
   logic [7:0]             pat_byte;
   logic [DUTY_W+7:0]      pat_prod;
   logic [PCT_W-1:0]       pct_sat;
   logic [SCALED_W+PCT_W-1:0] set_prod;
   logic                   running;

   assign cmd        = cmd_type'(req.command);
   assign cmd_mode   = mode_type'(req.command - 3'd1);
   assign is_pattern = (cur_rec.mode >= MODE_FLASH);

   // Step period of the current pattern mode.
   always_comb begin
      case (cur_rec.mode)
         MODE_SBREATH: period = cfg.slow_period;
         MODE_CODE:    period = cfg.code_period;
         default:      period = cfg.fast_period;
      endcase
   end

   // Saturating tick counter and step decision.
   assign tick_inc = (cur_tick == TICK_MAX) ? cur_tick : cur_tick + 1'b1;
   assign do_step  = (CMP_W'(tick_inc) >= CMP_W'(period)) || (tick_inc == TICK_MAX);

   // Position wrap at the length of the pattern now selected.
   assign pos_len  = (cur_rec.mode == MODE_CODE) ? POS_W'(SEQ_TOTAL) : POS_W'(PATTERN_LEN);
   assign pos_eff  = (cur_rec.position >= pos_len) ? '0 : cur_rec.position;
   assign pos_next = pos_eff + 1'b1;

   // Hamming(12,8) cells of the sequence id, even parity.
   always_comb begin
      code_bit = '0;
      for (int k = 0; k < 8; k++) begin
         code_bit[DATA_CELLS[k]] = cfg.seq_id[7-k];
      end
      code_bit[0] = code_bit[2] ^ code_bit[4] ^ code_bit[6] ^ code_bit[8] ^ code_bit[10];
      code_bit[1] = code_bit[2] ^ code_bit[5] ^ code_bit[6] ^ code_bit[9] ^ code_bit[10];
      code_bit[3] = code_bit[4] ^ code_bit[5] ^ code_bit[6] ^ code_bit[11];
      code_bit[7] = code_bit[8] ^ code_bit[9] ^ code_bit[10] ^ code_bit[11];
   end

   // Each set cell swaps the byte pair, so a pair is swapped when the running
   // parity of the cells up to it is one.
   always_comb begin
      flip    = '0;
      flip[0] = code_bit[0];
      for (int k = 1; k < 12; k++) begin
         flip[k] = flip[k-1] ^ code_bit[k];
      end
   end

   // Sequence pattern byte: sync bytes, then coded pairs.
   assign code_off = pos_eff - POS_W'(SYNC_LEN);
   always_comb begin
      if (pos_eff < POS_W'(SYNC_LEN)) begin
         code_byte = SYNC_BYTES[pos_eff[1:0]];
      end else if (code_off >= POS_W'(CODE_BYTES)) begin
         code_byte = '0;
      end else if (flip[code_off[4:1]] ^ code_off[0]) begin
         code_byte = CODE_Y;
      end else begin
         code_byte = CODE_X;
      end
   end

   // Pattern byte of the current mode.
   always_comb begin
      case (cur_rec.mode)
         MODE_CODE:    pat_byte = code_byte;
         MODE_FBREATH: pat_byte = FAST_BREATH_TAB[pos_eff[3:0]];
         MODE_SBREATH: pat_byte = SLOW_BREATH_TAB[pos_eff[3:0]];
         default:      pat_byte = FLASH_TAB[pos_eff[3:0]];
      endcase
   end

   // Duty scaling for a pattern step and for a set-duty command.
   assign pat_prod = (DUTY_W+8)'(pat_byte) * (DUTY_W+8)'(cfg.max_duty);
   assign pct_sat  = (req.duty_percent > PCT_FULL) ? PCT_FULL : req.duty_percent;
   assign set_prod = (SCALED_W+PCT_W)'(max_scaled) * (SCALED_W+PCT_W)'(pct_sat);

   // Command decoder.
   always_comb begin
      nxt_rec  = cur_rec;
      nxt_tick = cur_tick;
      unique case (cmd)
         CMD_TICK: begin
            if (is_pattern) begin
               if (do_step) begin
                  nxt_tick            = '0;
                  nxt_rec.position    = pos_next;
                  nxt_rec.duty_level  = pat_prod[DUTY_W+7:8];
               end else begin
                  nxt_tick = tick_inc;
               end
            end
         end
         CMD_OFF, CMD_ON: begin
            nxt_tick     = '0;
            nxt_rec.mode = cmd_mode;
         end
         CMD_DUTY: begin
            nxt_tick           = '0;
            nxt_rec.mode       = MODE_DUTY;
            nxt_rec.duty_level = set_prod[RECIP_SHIFT +: DUTY_W];
         end
         default: begin
            if (cur_rec.mode != cmd_mode) begin
               nxt_tick     = '0;
               nxt_rec.mode = cmd_mode;
            end
         end
      endcase
   end

   // Result item from the updated state.
   assign running         = (nxt_rec.mode >= MODE_DUTY);
   assign rsp.pwm_running = running;
   assign rsp.pin_level   = running ? 1'b0
                          : ((nxt_rec.mode == MODE_ON) ? cfg.active_level : ~cfg.active_level);
   assign rsp.duty_value  = running ? nxt_rec.duty_level : '0;
   assign rsp.mode        = nxt_rec.mode;

endmodule
